>>> rtl/core/sswp_pkg.sv
// shared types and constants for the scaler subevent word parser
// used by the front, queue, back and top-level modules; no dependencies

package sswp_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned AddrW     = 16;
  localparam int unsigned SizeW     = 8;
  localparam int unsigned CountW    = 16;
  localparam int unsigned IndexW    = 8;
  localparam int unsigned KindW     = 2;
  localparam int unsigned TimeW     = 35;
  localparam int unsigned CfgW      = 16;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned OutDataW  = 80;
  localparam int unsigned OutUserW  = 3;

  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [CfgW-1:0]  BoardAddrLimitRst = 16'd255;
  localparam logic [CfgW-1:0]  ExtLimitRst       = 16'd128;
  localparam logic [SizeW-1:0] HeaderWords       = 8'd4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BOARD_ADDR_LIMIT = 1'b0,
    CFG_EXT_LIMIT        = 1'b1
  } cfg_idx_e;

  typedef enum logic [KindW-1:0] {
    KIND_SCALER   = 2'd0,
    KIND_SIZE_ERR = 2'd1,
    KIND_EXT_ERR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_FIRST  = 3'd1,
    PH_SECOND = 3'd2,
    PH_EXT    = 3'd3,
    PH_LATCH  = 3'd4,
    PH_EMPTY  = 3'd5,
    PH_SCALER = 3'd6,
    PH_SKIP   = 3'd7
  } phase_e;

  // one classified result on its way from front to back
  typedef struct packed {
    kind_e             kind;
    logic [IndexW-1:0] index;
    logic [WordW-1:0]  value;
    logic              first;
  } entry_t;

endpackage

>>> rtl/core/sswp_front.sv
// front: configuration registers and the block parsing state machine
// classifies each input beat and pushes result entries; uses sswp_pkg

module sswp_front import sswp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  cfg_idx_e           cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [WordW-1:0]   in_word_i,
  input  logic               in_start_i,
  input  logic               q_full_i,
  output logic               push_o,
  output entry_t             push_entry_o
);

  logic [CfgW-1:0]   addr_limit_q, ext_limit_q;
  phase_e            phase_q, phase_d, phase_e_w;
  logic [CountW-1:0] left_q, left_d, left_e, left_dec;
  logic [SizeW-1:0]  size_q, size_d, size_e;
  logic [IndexW-1:0] cnt_q, cnt_d, cnt_e;
  logic              discard_q, discard_d, discard_e;
  logic              accept;
  logic [SizeW-1:0]  hdr_size;
  logic [CountW-1:0] ext_cnt;
  logic              size_bad, ext_bad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_limit_q <= BoardAddrLimitRst;
      ext_limit_q  <= ExtLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BOARD_ADDR_LIMIT: addr_limit_q <= cfg_data_i;
        CFG_EXT_LIMIT:        ext_limit_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // a subevent start clears the parser before the beat is looked at
  always_comb begin
    if (in_start_i) begin
      phase_e_w = PH_HEADER;
      left_e    = '0;
      size_e    = '0;
      cnt_e     = '0;
      discard_e = 1'b0;
    end else begin
      phase_e_w = phase_q;
      left_e    = left_q;
      size_e    = size_q;
      cnt_e     = cnt_q;
      discard_e = discard_q;
    end
  end

  assign hdr_size = in_word_i[23:16];
  assign ext_cnt  = in_word_i[CountW-1:0];
  assign left_dec = left_e - CountW'(1);
  assign size_bad = in_word_i[SizeW-1:0] != size_e;
  assign ext_bad  = (ext_cnt != '0) && (ext_cnt >= ext_limit_q);

  // next state
  always_comb begin
    phase_d   = phase_e_w;
    left_d    = left_e;
    size_d    = size_e;
    cnt_d     = cnt_e;
    discard_d = discard_e;
    if (!discard_e) begin
      case (phase_e_w)
        PH_HEADER: begin
          size_d = hdr_size;
          if (in_word_i[AddrW-1:0] > addr_limit_q) begin
            left_d  = CountW'(hdr_size);
            phase_d = (hdr_size != '0) ? PH_SKIP : PH_HEADER;
          end else begin
            phase_d = PH_FIRST;
          end
        end
        PH_FIRST: begin
          if (size_bad) discard_d = 1'b1;
          else          phase_d   = PH_SECOND;
        end
        PH_SECOND: begin
          if (ext_bad) begin
            discard_d = 1'b1;
          end else begin
            left_d  = ext_cnt;
            phase_d = (ext_cnt != '0) ? PH_EXT : PH_LATCH;
          end
        end
        PH_EXT: begin
          left_d = left_dec;
          if (left_dec == '0) phase_d = PH_LATCH;
        end
        PH_LATCH: phase_d = PH_EMPTY;
        PH_EMPTY: begin
          if (size_e > HeaderWords) begin
            left_d  = CountW'(size_e - HeaderWords);
            cnt_d   = '0;
            phase_d = PH_SCALER;
          end else begin
            phase_d = PH_HEADER;
          end
        end
        PH_SCALER: begin
          cnt_d  = cnt_e + IndexW'(1);
          left_d = left_dec;
          if (left_dec == '0) phase_d = PH_HEADER;
        end
        default: begin
          left_d = left_dec;
          if (left_dec == '0) phase_d = PH_HEADER;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    push_o             = 1'b0;
    push_entry_o.kind  = KIND_SCALER;
    push_entry_o.index = '0;
    push_entry_o.value = '0;
    push_entry_o.first = 1'b0;
    if (accept && !discard_e) begin
      case (phase_e_w)
        PH_FIRST: begin
          if (size_bad) begin
            push_o            = 1'b1;
            push_entry_o.kind = KIND_SIZE_ERR;
          end
        end
        PH_SECOND: begin
          if (ext_bad) begin
            push_o            = 1'b1;
            push_entry_o.kind = KIND_EXT_ERR;
          end
        end
        PH_SCALER: begin
          push_o             = 1'b1;
          push_entry_o.index = cnt_e;
          push_entry_o.value = in_word_i;
          push_entry_o.first = cnt_e == '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      left_q    <= '0;
      size_q    <= '0;
      cnt_q     <= '0;
      discard_q <= 1'b0;
    end else if (accept) begin
      phase_q   <= phase_d;
      left_q    <= left_d;
      size_q    <= size_d;
      cnt_q     <= cnt_d;
      discard_q <= discard_d;
    end
  end

endmodule

>>> rtl/core/sswp_queue.sv
// short flop-based fifo of result entries between front and back
// uses sswp_pkg for the entry type

module sswp_queue import sswp_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output entry_t pop_entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign full_o      = count_q == CntW'(Depth);
  assign empty_o     = count_q == '0;
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && !empty_o;
  assign pop_entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/sswp_back.sv
// back: pops result entries, forms the spill time and holds the output beat
// uses sswp_pkg

module sswp_back import sswp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  entry_t             q_entry_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output kind_e              out_kind_o,
  output logic [IndexW-1:0]  out_index_o,
  output logic [WordW-1:0]   out_value_o,
  output logic               out_time_valid_o,
  output logic [TimeW-1:0]   out_time_o
);

  logic              valid_q;
  kind_e             kind_q;
  logic [IndexW-1:0] index_q;
  logic [WordW-1:0]  value_q;
  logic              tv_q;
  logic [TimeW-1:0]  time_q, time_d;

  assign pop_o = !q_empty_i && (!valid_q || out_ready_i);

  // value * 5 as value * 4 + value
  always_comb begin
    time_d = '0;
    if (q_entry_i.first) begin
      time_d = (TimeW'(q_entry_i.value) << 2) + TimeW'(q_entry_i.value);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q  <= q_entry_i.kind;
      index_q <= q_entry_i.index;
      value_q <= q_entry_i.value;
      tv_q    <= q_entry_i.first;
      time_q  <= time_d;
    end
  end

  assign out_valid_o      = valid_q;
  assign out_kind_o       = kind_q;
  assign out_index_o      = index_q;
  assign out_value_o      = value_q;
  assign out_time_valid_o = tv_q;
  assign out_time_o       = time_q;

endmodule

>>> rtl/core/scaler_subevent_word_parser.sv
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid_i/tready_o      tdata data_word, tuser subevent_start
// m_axis    out  m_axis_tvalid_o/tready_i      tdata index/value/time, tuser kind/time_valid
// cfg       in   cfg_we_i (no wait)            cfg_idx_i, cfg_data_i
//
// one input beat per cycle while the queue has room; each result is held in the queue and
// then in the output register; the front state machine decides each accepted beat, the
// back adds value*5; a four-entry queue decouples them: the input stalls only when full
// reset clears parser state, queue and output; no clearing pass
// top level of the scaler subevent word parser; uses sswp_pkg, sswp_front,
// sswp_queue and sswp_back

module scaler_subevent_word_parser import sswp_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [WordW-1:0]    s_axis_tdata_i,   // [31:0] data_word
  input  logic                s_axis_tuser_i,   // [0] subevent_start
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [7:0] scaler_index, [39:8] scaler_value, [74:40] time_in_spill_ns, [79:75] zero
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // [1:0] result_kind, [2] time_valid
  output logic [OutUserW-1:0] m_axis_tuser_o
);

  logic              q_full, q_empty, push, pop;
  entry_t            push_entry, pop_entry;
  kind_e             out_kind;
  logic [IndexW-1:0] out_index;
  logic [WordW-1:0]  out_value;
  logic              out_tv;
  logic [TimeW-1:0]  out_time;

  sswp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_e'(cfg_idx_i)),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_word_i    (s_axis_tdata_i),
    .in_start_i   (s_axis_tuser_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  sswp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .empty_o      (q_empty),
    .pop_entry_o  (pop_entry)
  );

  sswp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_entry_i        (pop_entry),
    .pop_o            (pop),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .out_kind_o       (out_kind),
    .out_index_o      (out_index),
    .out_value_o      (out_value),
    .out_time_valid_o (out_tv),
    .out_time_o       (out_time)
  );

  assign m_axis_tdata_o = {5'b0, out_time, out_value, out_index};
  assign m_axis_tuser_o = {out_tv, out_kind};

`ifndef SYNTH
  a_time_only_scaler: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && out_tv |-> out_kind == KIND_SCALER)
    else $error("time_valid on a non-scaler result");

  a_time_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && out_tv |-> out_time == (TimeW'(out_value) * TimeW'(5)))
    else $error("spill time does not match scaler value");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && out_kind != KIND_SCALER |->
      out_index == '0 && out_value == '0 && !out_tv)
    else $error("error result carries payload");

  a_kind_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> out_kind == KIND_SCALER || out_kind == KIND_SIZE_ERR ||
      out_kind == KIND_EXT_ERR)
    else $error("undefined result kind");
`endif

endmodule

>>> tb/testbench.sv
// self-checking testbench for scaler_subevent_word_parser: random subevents, random
// idling on both sides, results checked against an in-bench predictor
// depends on sswp_pkg and the parser RTL only

module testbench;
  import sswp_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned IdlePct    = 22;
  localparam int unsigned HoldCycles = 150;
  localparam int unsigned SettleWait = 8;

  typedef struct packed {
    kind_e              kind;
    logic [IndexW-1:0]  index;
    logic [WordW-1:0]   value;
    logic               time_valid;
    logic [TimeW-1:0]   spill_ns;
  } readout_t;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             start;
  } beat_t;

  // tracks the parser state and the readouts it owes
  class scaler_tracker;
    logic [CfgW-1:0]   addr_limit;
    logic [CfgW-1:0]   ext_limit;
    phase_e            phase;
    logic [CountW-1:0] words_left;
    logic [SizeW-1:0]  block_size;
    logic [IndexW-1:0] scaler_idx;
    bit                discarding;
    readout_t          due_results[$];
    int unsigned errors, results_seen, n_beats, n_scalers, n_timed, n_size_err, n_ext_err;

    function new();
      addr_limit = BoardAddrLimitRst;
      ext_limit  = ExtLimitRst;
      errors = 0; results_seen = 0; n_beats = 0;
      n_scalers = 0; n_timed = 0; n_size_err = 0; n_ext_err = 0;
      restart();
    endfunction

    function void restart();
      phase      = PH_HEADER;
      words_left = '0;
      block_size = '0;
      scaler_idx = '0;
      discarding = 1'b0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgW-1:0] val);
      if (idx == CFG_BOARD_ADDR_LIMIT) addr_limit = val;
      else ext_limit = val;
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    // note one accepted input beat and queue the readout it causes, if any
    function void take_word(logic [WordW-1:0] w, logic start);
      readout_t          r;
      logic [CountW-1:0] cnt;
      logic [TimeW-1:0]  wide;
      n_beats++;
      if (start) restart();
      if (discarding) return;
      r = '0;
      case (phase)
        PH_HEADER: begin
          block_size = w[23:16];
          if (w[15:0] > addr_limit) begin
            words_left = CountW'(block_size);
            phase = (block_size != '0) ? PH_SKIP : PH_HEADER;
          end else begin
            phase = PH_FIRST;
          end
        end
        PH_FIRST: begin
          if (w[7:0] != block_size) begin
            discarding = 1'b1;
            r.kind = KIND_SIZE_ERR;
            due_results.push_back(r);
            n_size_err++;
          end else begin
            phase = PH_SECOND;
          end
        end
        PH_SECOND: begin
          cnt = w[15:0];
          if (cnt != '0 && cnt >= ext_limit) begin
            discarding = 1'b1;
            r.kind = KIND_EXT_ERR;
            due_results.push_back(r);
            n_ext_err++;
          end else begin
            words_left = cnt;
            phase = (cnt != '0) ? PH_EXT : PH_LATCH;
          end
        end
        PH_EXT: begin
          words_left = words_left - 1'b1;
          if (words_left == '0) phase = PH_LATCH;
        end
        PH_LATCH: phase = PH_EMPTY;
        PH_EMPTY: begin
          if (block_size > HeaderWords) begin
            words_left = CountW'(block_size - HeaderWords);
            scaler_idx = '0;
            phase = PH_SCALER;
          end else begin
            phase = PH_HEADER;
          end
        end
        PH_SCALER: begin
          r.kind  = KIND_SCALER;
          r.index = scaler_idx;
          r.value = w;
          if (scaler_idx == '0) begin
            wide = TimeW'(w);
            r.time_valid = 1'b1;
            r.spill_ns = wide * TimeW'(5);
            n_timed++;
          end
          due_results.push_back(r);
          n_scalers++;
          scaler_idx = scaler_idx + 1'b1;
          words_left = words_left - 1'b1;
          if (words_left == '0) phase = PH_HEADER;
        end
        default: begin
          words_left = words_left - 1'b1;
          if (words_left == '0) phase = PH_HEADER;
        end
      endcase
    endfunction

    function void report(string field, logic [63:0] want, logic [63:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endfunction

    function void check_result(logic [OutDataW-1:0] data, logic [OutUserW-1:0] user);
      readout_t want;
      results_seen++;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual kind %0d index %0d value %0h",
                 $time, user[1:0], data[7:0], data[39:8]);
        return;
      end
      want = due_results.pop_front();
      if (user[1:0] !== want.kind)          report("result_kind", want.kind, user[1:0]);
      if (user[2] !== want.time_valid)      report("time_valid", want.time_valid, user[2]);
      if (data[7:0] !== want.index)         report("scaler_index", want.index, data[7:0]);
      if (data[39:8] !== want.value)        report("scaler_value", want.value, data[39:8]);
      if (data[74:40] !== want.spill_ns)
        report("time_in_spill_ns", want.spill_ns, data[74:40]);
      if (data[79:75] !== 5'b0)             report("tdata padding", 0, data[79:75]);
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgW-1:0]     cfg_data_i;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [WordW-1:0]    s_axis_tdata_i;
  logic                s_axis_tuser_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [OutUserW-1:0] m_axis_tuser_o;

  scaler_tracker sb;
  beat_t         stim_beats[$];
  bit            open_subevent;
  bit            want_full_block;
  bit            steady;
  logic [CfgW-1:0] board_limit;
  logic [CfgW-1:0] ext_limit;
  int unsigned   cycle_count = 0;

  scaler_subevent_word_parser dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d readouts still due", cycle_count, sb.pending());
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off once 60 results have been checked
  initial begin : result_sink
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held = 1'b0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (!held && sb.results_seen >= 60) begin
        held = 1'b1;
        hold_left = HoldCycles;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= steady || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  task automatic push_word(input logic [WordW-1:0] w);
    stim_beats.push_back('{word: w, start: open_subevent});
    open_subevent = 1'b0;
  endtask

  task automatic add_block(input bit truncate);
    logic [WordW-1:0]  blk[$];
    logic [SizeW-1:0]  size;
    logic [AddrW-1:0]  addr;
    logic [CountW-1:0] cnt;
    logic [7:0]        low;
    int unsigned       r, hi, keep, n_ext;
    r = $urandom_range(99);
    if (r < 12 && board_limit != 16'hFFFF) begin
      // block from a board above the limit: header plus size words to skip
      size = 8'($urandom_range(5));
      addr = 16'($urandom_range(65535, int'(board_limit) + 1));
      blk.push_back({8'($urandom), size, addr});
      repeat (size) blk.push_back($urandom);
    end else begin
      addr = ($urandom_range(7) == 0) ? board_limit : 16'($urandom_range(board_limit));
      r = $urandom_range(99);
      if (want_full_block) size = 8'hFF;
      else if (r < 15) size = 8'($urandom_range(3));
      else size = 8'($urandom_range(14, 4));
      want_full_block = 1'b0;
      blk.push_back({8'($urandom), size, addr});
      low = ($urandom_range(99) < 6) ? size ^ 8'($urandom_range(255, 1)) : size;
      blk.push_back({24'($urandom), low});
      r = $urandom_range(99);
      hi = (ext_limit > 5) ? 4 : ext_limit - 1;
      if (r < 7) cnt = 16'($urandom_range(65535, ext_limit));
      else if (r < 45) cnt = '0;
      else cnt = 16'($urandom_range(hi));
      blk.push_back({16'($urandom), cnt});
      n_ext = (cnt >= ext_limit) ? 2 : cnt;
      repeat (n_ext) blk.push_back($urandom);
      blk.push_back($urandom);  // latch word
      blk.push_back($urandom);  // empty word
      if (size > HeaderWords) begin
        repeat (size - HeaderWords) begin
          r = $urandom_range(19);
          blk.push_back(r == 0 ? 32'hFFFF_FFFF : r == 1 ? 32'h0 : $urandom);
        end
      end
    end
    if (truncate && blk.size() > 1) begin
      keep = $urandom_range(blk.size() - 1, 1);
      while (blk.size() > keep) void'(blk.pop_back());
    end
    foreach (blk[i]) push_word(blk[i]);
  endtask

  task automatic add_subevent();
    int unsigned sel, nblk;
    sel = $urandom_range(99);
    open_subevent = 1'b1;
    if (sel < 5) begin
      repeat ($urandom_range(6, 1)) push_word($urandom);
    end else begin
      nblk = $urandom_range(3, 1);
      for (int i = 0; i < nblk; i++) add_block(sel >= 88 && i == nblk - 1);
    end
  endtask

  task automatic add_directed();
    // words before any subevent start, block cut off by the next start
    open_subevent = 1'b0;
    push_word({8'h00, 8'd4, 16'h00FF});
    push_word(32'hFFFF_FF04);
    push_word(32'hFFFF_0000);
    push_word(32'hFFFF_FFFF);
    // one extension word, scaler 0 at full scale, scaler 1 at zero
    open_subevent = 1'b1;
    push_word({8'hFF, 8'd6, 16'h0001});
    push_word(32'h0000_0006);
    push_word(32'h0000_0001);
    push_word(32'h1234_5678);
    push_word(32'h0000_0000);
    push_word(32'hFFFF_FFFF);
    push_word(32'hFFFF_FFFF);
    push_word(32'h0000_0000);
    // skipped blocks of size 0 and 1
    push_word({8'h5A, 8'd0, 16'h0100});
    push_word({8'h00, 8'd1, 16'hFFFF});
    push_word(32'hA5A5_A5A5);
    // size mismatch, then a discarded word
    open_subevent = 1'b1;
    push_word({8'h00, 8'd5, 16'h0003});
    push_word(32'h0000_0004);
    push_word(32'h0000_0005);
    // extension count equal to the limit
    open_subevent = 1'b1;
    push_word({8'h00, 8'd5, 16'h0000});
    push_word(32'h0000_0005);
    push_word(32'h0000_0080);
    push_word(32'hFFFF_FFFF);
  endtask

  task automatic send_beat(input beat_t b);
    while (!steady && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b.word;
    s_axis_tuser_i  <= b.start;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.take_word(b.word, b.start);
  endtask

  // fill to at least n beats with random subevents, send them and wait for every readout
  task automatic run_phase(input int unsigned n);
    while (stim_beats.size() < n) add_subevent();
    while (stim_beats.size() != 0) send_beat(stim_beats.pop_front());
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [CfgW-1:0] addr_val, input logic [CfgW-1:0] ext_val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_BOARD_ADDR_LIMIT;
    cfg_data_i <= addr_val;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_EXT_LIMIT;
    cfg_data_i <= ext_val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_reg(CFG_BOARD_ADDR_LIMIT, addr_val);
    sb.set_reg(CFG_EXT_LIMIT, ext_val);
    board_limit = addr_val;
    ext_limit   = ext_val;
  endtask

  initial begin
    sb = new();
    open_subevent = 1'b0;
    want_full_block = 1'b0;
    steady = 1'b0;
    board_limit = BoardAddrLimitRst;
    ext_limit   = ExtLimitRst;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_BOARD_ADDR_LIMIT;
    cfg_data_i = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_directed();
    run_phase(320);

    // only board 0 parsed, every nonzero extension count rejected
    write_regs(16'h0000, 16'h0001);
    run_phase(260);

    // nothing skipped, widest extension window, one full-size block, no idling
    write_regs(16'hFFFF, 16'hFFFF);
    steady = 1'b1;
    want_full_block = 1'b1;
    run_phase(300);
    steady = 1'b0;

    write_regs(16'($urandom), 16'($urandom_range(65535, 1)));
    run_phase(320);

    $display("covered %0d beats under 4 register settings: %0d scaler readouts",
             sb.n_beats, sb.n_scalers);
    $display("(%0d with spill time), %0d size mismatch and %0d extension count errors, %0d mismatches found",
             sb.n_timed, sb.n_size_err, sb.n_ext_err, sb.errors);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
